/* rtl/core/idc_pkg.sv */
// Shared types, constants and month table for the Islamic date converter.
`timescale 1ns / 1ps

package idc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 23;
    localparam int YQ_W    = 15;
    localparam int KSUM_W  = 24;
    localparam int NUM_W   = 28;
    localparam int SUM_W   = 25;
    localparam int MOFF_W  = 9;
    localparam int DATA_W  = 48;

    localparam logic [DN_W-1:0] EPOCH_RESET = 23'd1948439;

    localparam int CYCLE_DAYS  = 10631;
    localparam int CYCLE_BIAS  = 10646;
    localparam int CYCLE_YEARS = 30;
    localparam int LEAP_STEP   = 11;
    localparam int LEAP_BIAS   = 3;
    localparam int YEAR_DAYS   = 354;
    localparam int MONTH_MAX   = 12;
    localparam int DAY_MAX     = 30;

    localparam int DIVY_SHIFT = 42;
    localparam int DIVY_MUL_W = 29;
    localparam logic [DIVY_MUL_W-1:0] DIVY_MUL =
        DIVY_MUL_W'(((64'd1 << DIVY_SHIFT) + 64'(CYCLE_DAYS) - 64'd1) / 64'(CYCLE_DAYS));

    localparam int LEAPN_W     = 19;
    localparam int DIV30_SHIFT = 24;
    localparam int DIV30_MUL_W = 20;
    localparam logic [DIV30_MUL_W-1:0] DIV30_MUL =
        DIV30_MUL_W'(((64'd1 << DIV30_SHIFT) + 64'(CYCLE_YEARS) - 64'd1) / 64'(CYCLE_YEARS));

    typedef enum logic {
        OP_DATE_TO_NUM = 1'b0,
        OP_NUM_TO_DATE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DN_W-1:0]    day_number;
    } item_t;

    typedef struct packed {
        logic [DN_W-1:0]    day_number;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               ok;
    } result_t;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
        logic adv_c;
        logic adv_d;
        logic adv_e;
    } stage_ctl_t;

    // days before the first of month m: ceil(59*(m-1)/2)
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] off;
        unique case (m)
            4'd1:    off = 9'd0;
            4'd2:    off = 9'd30;
            4'd3:    off = 9'd59;
            4'd4:    off = 9'd89;
            4'd5:    off = 9'd118;
            4'd6:    off = 9'd148;
            4'd7:    off = 9'd177;
            4'd8:    off = 9'd207;
            4'd9:    off = 9'd236;
            4'd10:   off = 9'd266;
            4'd11:   off = 9'd295;
            4'd12:   off = 9'd325;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

/* rtl/core/idc_datapath.sv */
// Pipelined arithmetic of the date and day number conversion.
`timescale 1ns / 1ps

module idc_datapath (
    input  logic                         aclk,
    input  idc_pkg::stage_ctl_t          ctl,
    input  idc_pkg::item_t               item,
    input  logic [idc_pkg::DN_W-1:0]     epoch,
    output idc_pkg::result_t             res
);

    typedef struct packed {
        idc_pkg::op_t                 op;
        logic                         ok;
        logic [idc_pkg::YEAR_W-1:0]   year;
        logic [idc_pkg::DN_W-1:0]     x;
        logic [idc_pkg::KSUM_W-1:0]   k;
        logic [idc_pkg::NUM_W-1:0]    n;
    } stage_a_t;

    typedef struct packed {
        idc_pkg::op_t                 op;
        logic                         ok;
        logic [idc_pkg::YQ_W-1:0]     y;
        logic [idc_pkg::DN_W-1:0]     x;
        logic [idc_pkg::KSUM_W-1:0]   k;
    } stage_b_t;

    typedef struct packed {
        idc_pkg::op_t                 op;
        logic                         ok;
        logic [idc_pkg::YEAR_W-1:0]   y;
        logic [idc_pkg::DN_W-1:0]     x;
        logic [idc_pkg::KSUM_W-1:0]   k;
        logic [idc_pkg::KSUM_W-1:0]   a;
        logic [idc_pkg::YQ_W-1:0]     f;
    } stage_c_t;

    typedef struct packed {
        idc_pkg::op_t                 op;
        logic                         ok;
        logic [idc_pkg::YEAR_W-1:0]   y;
        logic [idc_pkg::DN_W-1:0]     x;
        logic [idc_pkg::KSUM_W-1:0]   k;
        logic [idc_pkg::KSUM_W-1:0]   yoff;
    } stage_d_t;

    typedef struct packed {
        idc_pkg::op_t                 op;
        logic                         ok;
        logic [idc_pkg::YEAR_W-1:0]   y;
        logic [idc_pkg::SUM_W-1:0]    s;
    } stage_e_t;

    stage_a_t a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;
    stage_d_t d_reg, d_next;
    stage_e_t e_reg, e_next;

    logic                                               fields_ok;
    logic [idc_pkg::NUM_W+idc_pkg::DIVY_MUL_W-1:0]      prod_y;
    logic [idc_pkg::LEAPN_W-1:0]                        leap_n;
    logic [idc_pkg::LEAPN_W+idc_pkg::DIV30_MUL_W-1:0]   prod_30;
    logic [idc_pkg::SUM_W-1:0]                          r_sum;
    logic [idc_pkg::SUM_W-1:0]                          t_diff;
    logic [idc_pkg::MONTH_W-1:0]                        mon;
    logic signed [idc_pkg::SUM_W-1:0]                   dd;
    logic                                               day_ok;

    // entry: field checks, offset from epoch, scaled numerator
    always_comb begin
        fields_ok = (item.year != '0)
                 && (item.month >= idc_pkg::MONTH_W'(1))
                 && (item.month <= idc_pkg::MONTH_W'(idc_pkg::MONTH_MAX))
                 && (item.day >= idc_pkg::DAY_W'(1))
                 && (item.day <= idc_pkg::DAY_W'(idc_pkg::DAY_MAX));
        a_next.op   = item.op;
        a_next.ok   = (item.op == idc_pkg::OP_NUM_TO_DATE) ? (item.day_number >= epoch)
                                                           : fields_ok;
        a_next.year = item.year;
        a_next.x    = item.day_number - epoch;
        a_next.k    = idc_pkg::KSUM_W'(idc_pkg::month_offset(item.month))
                    + idc_pkg::KSUM_W'(item.day)
                    + idc_pkg::KSUM_W'(epoch)
                    - idc_pkg::KSUM_W'(1);
        a_next.n    = idc_pkg::NUM_W'(a_next.x) * idc_pkg::NUM_W'(idc_pkg::CYCLE_YEARS)
                    + idc_pkg::NUM_W'(idc_pkg::CYCLE_BIAS);
    end

    // year by reciprocal of the cycle length
    always_comb begin
        prod_y = (idc_pkg::NUM_W+idc_pkg::DIVY_MUL_W)'(a_reg.n)
               * (idc_pkg::NUM_W+idc_pkg::DIVY_MUL_W)'(idc_pkg::DIVY_MUL);
        b_next.op = a_reg.op;
        b_next.ok = a_reg.ok;
        b_next.x  = a_reg.x;
        b_next.k  = a_reg.k;
        b_next.y  = (a_reg.op == idc_pkg::OP_NUM_TO_DATE)
                  ? prod_y[idc_pkg::DIVY_SHIFT +: idc_pkg::YQ_W]
                  : idc_pkg::YQ_W'(a_reg.year);
    end

    // common years and leap day count
    always_comb begin
        leap_n  = idc_pkg::LEAPN_W'(b_reg.y) * idc_pkg::LEAPN_W'(idc_pkg::LEAP_STEP)
                + idc_pkg::LEAPN_W'(idc_pkg::LEAP_BIAS);
        prod_30 = (idc_pkg::LEAPN_W+idc_pkg::DIV30_MUL_W)'(leap_n)
                * (idc_pkg::LEAPN_W+idc_pkg::DIV30_MUL_W)'(idc_pkg::DIV30_MUL);
        c_next.op = b_reg.op;
        c_next.ok = b_reg.ok && ((b_reg.op == idc_pkg::OP_DATE_TO_NUM)
                                 || (b_reg.y[idc_pkg::YQ_W-1] == 1'b0));
        c_next.y  = b_reg.y[idc_pkg::YEAR_W-1:0];
        c_next.x  = b_reg.x;
        c_next.k  = b_reg.k;
        c_next.a  = idc_pkg::KSUM_W'(b_reg.y) * idc_pkg::KSUM_W'(idc_pkg::YEAR_DAYS)
                  - idc_pkg::KSUM_W'(idc_pkg::YEAR_DAYS);
        c_next.f  = prod_30[idc_pkg::DIV30_SHIFT +: idc_pkg::YQ_W];
    end

    always_comb begin
        d_next.op   = c_reg.op;
        d_next.ok   = c_reg.ok;
        d_next.y    = c_reg.y;
        d_next.x    = c_reg.x;
        d_next.k    = c_reg.k;
        d_next.yoff = c_reg.a + idc_pkg::KSUM_W'(c_reg.f);
    end

    // day number for dates, day within year for numbers
    always_comb begin
        r_sum  = idc_pkg::SUM_W'(d_reg.yoff) + idc_pkg::SUM_W'(d_reg.k);
        t_diff = idc_pkg::SUM_W'(d_reg.x) - idc_pkg::SUM_W'(d_reg.yoff);
        e_next.op = d_reg.op;
        e_next.y  = d_reg.y;
        if (d_reg.op == idc_pkg::OP_NUM_TO_DATE) begin
            e_next.s  = t_diff;
            e_next.ok = d_reg.ok;
        end else begin
            e_next.s  = r_sum;
            e_next.ok = d_reg.ok && (r_sum[idc_pkg::SUM_W-1:idc_pkg::DN_W] == '0);
        end
    end

    // month by threshold count, then day of month
    always_comb begin
        mon = idc_pkg::MONTH_W'(1);
        for (int m = 2; m <= idc_pkg::MONTH_MAX; m++) begin
            if ($signed(e_reg.s)
                    >= $signed(idc_pkg::SUM_W'(idc_pkg::month_offset(idc_pkg::MONTH_W'(m)))))
            begin
                mon = mon + idc_pkg::MONTH_W'(1);
            end
        end
        dd     = $signed(e_reg.s)
               - $signed(idc_pkg::SUM_W'(idc_pkg::month_offset(mon)))
               + $signed(idc_pkg::SUM_W'(1));
        day_ok = (dd >= $signed(idc_pkg::SUM_W'(1)))
              && (dd <= $signed(idc_pkg::SUM_W'(idc_pkg::DAY_MAX)));
        res = '0;
        if (e_reg.op == idc_pkg::OP_NUM_TO_DATE) begin
            res.ok = e_reg.ok && day_ok;
            if (res.ok) begin
                res.year  = e_reg.y;
                res.month = mon;
                res.day   = dd[idc_pkg::DAY_W-1:0];
            end
        end else begin
            res.ok = e_reg.ok;
            if (res.ok) begin
                res.day_number = e_reg.s[idc_pkg::DN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv_a) begin
            a_reg <= a_next;
        end
        if (ctl.adv_b) begin
            b_reg <= b_next;
        end
        if (ctl.adv_c) begin
            c_reg <= c_next;
        end
        if (ctl.adv_d) begin
            d_reg <= d_next;
        end
        if (ctl.adv_e) begin
            e_reg <= e_next;
        end
    end

endmodule

/* rtl/core/islamic_date_day_number_convert_top.sv */
// Top level of the Islamic date and day number converter: handshake, epoch and output register.
//
//  channel | direction | handshake               | payload
//  s_      | in        | s_tvalid / s_tready     | s_tuser op, s_tdata date and day number
//  m_      | out       | m_tvalid / m_tready     | m_tuser valid_res, m_tdata result fields
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_data epoch_day
//
// One request per cycle while s_tready is high; a result is presented after the five
// arithmetic stages (the first loaded at the accepting edge) and the output register;
// the two constant-reciprocal multiplies set the cut. aresetn clears every valid bit
// and loads epoch_day with 1948439.
// A stage moves whenever the one after it is empty or moving, so bubbles close up and
// requests keep entering while a result waits at m_.
`timescale 1ns / 1ps

module islamic_date_day_number_convert_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [idc_pkg::DATA_W-1:0]   s_tdata,   // in_year, in_month, in_day, in_day_number
    input  logic                         s_tuser,   // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [idc_pkg::DATA_W-1:0]   m_tdata,   // out_day_number, out_year, out_month, out_day
    output logic                         m_tuser,   // valid_res
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [idc_pkg::DN_W-1:0]     cfg_data
);

    localparam int STAGES = 5;

    logic [idc_pkg::DN_W-1:0] epoch_reg, epoch_next;
    logic [STAGES-1:0]        vld_reg, vld_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    idc_pkg::result_t         res_reg, res_next;
    logic [STAGES:0]          adv;
    idc_pkg::stage_ctl_t      ctl;
    idc_pkg::item_t           item;

    assign item.op         = idc_pkg::op_t'(s_tuser);
    assign item.year       = s_tdata[13:0];
    assign item.month      = s_tdata[17:14];
    assign item.day        = s_tdata[22:18];
    assign item.day_number = s_tdata[45:23];

    idc_datapath u_datapath (
        .aclk  (aclk),
        .ctl   (ctl),
        .item  (item),
        .epoch (epoch_reg),
        .res   (res_next)
    );

    // advance a stage when the next one is empty or advancing
    always_comb begin
        adv[STAGES] = !m_tvalid_reg || m_tready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
        m_tvalid_next = adv[STAGES] ? vld_reg[STAGES-1] : m_tvalid_reg;
        epoch_next    = (cfg_valid && cfg_ready) ? cfg_data : epoch_reg;
    end

    assign ctl.adv_a = adv[0];
    assign ctl.adv_b = adv[1];
    assign ctl.adv_c = adv[2];
    assign ctl.adv_d = adv[3];
    assign ctl.adv_e = adv[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg    <= idc_pkg::EPOCH_RESET;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            epoch_reg    <= epoch_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (adv[STAGES]) begin
            res_reg <= res_next;
        end
    end

    assign s_tready  = adv[0];
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = res_reg.ok;
    assign m_tdata   = {2'b00, res_reg.day, res_reg.month, res_reg.year, res_reg.day_number};

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected request carries nonzero result fields");

    a_date_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && (m_tdata[36:23] != '0)
        |-> (m_tdata[40:37] >= 4'd1) && (m_tdata[40:37] <= 4'd12)
            && (m_tdata[45:41] >= 5'd1) && (m_tdata[45:41] <= 5'd30)
            && (m_tdata[22:0] == '0))
        else $error("converted date out of range");

    a_accept_on_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && (vld_reg != '1) |-> s_tready)
        else $error("input held off while the pipeline has a free stage");

    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn)
        |-> $countones({vld_reg, m_tvalid_reg})
            == $past($countones({vld_reg, m_tvalid_reg}))
               + $past(int'(s_tvalid && s_tready))
               - $past(int'(m_tvalid && m_tready)))
        else $error("request lost or duplicated in the pipeline");

endmodule
